### rtl/dle_stx_etx_deframer_crc16_top_macros.svh
// Assertion macros for the DLE/STX/ETX deframer.
`ifndef DLE_STX_ETX_DEFRAMER_CRC16_TOP_MACROS_SVH
`define DLE_STX_ETX_DEFRAMER_CRC16_TOP_MACROS_SVH

`ifndef SYNTH
// Check that prop holds at every rising clock edge outside reset.
`define DSEDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");
// Check that expr is never true outside reset.
`define DSEDF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("deframer forbidden condition");
`else
`define DSEDF_ASSERT(lbl, prop)
`define DSEDF_NEVER(lbl, expr)
`endif

`endif

### rtl/dsedf_pkg.sv
// Shared types, constants and the CRC byte function of the deframer.
`timescale 1ns / 1ps
`default_nettype none
package dsedf_pkg;

  localparam int LEN_W      = 11;
  localparam int MAX_PACKET = 1024;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  localparam logic [7:0]  CH_STX   = 8'h02;
  localparam logic [7:0]  CH_ETX   = 8'h03;
  localparam logic [7:0]  CH_DLE   = 8'h10;
  localparam logic [7:0]  ESC_FLIP = 8'h40;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    TK_BYTE,
    TK_STX,
    TK_ETX,
    TK_DLE,
    TK_TIMEOUT
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  rx_byte;
  } token_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_BODY,
    PH_BODY_ESC,
    PH_CRC0,
    PH_CRC0_ESC,
    PH_CRC1,
    PH_CRC1_ESC
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_CRC_ERR,
    ST_TIMEOUT,
    ST_OVERRUN
  } status_t;

  // Queue handshake between the front and back sides.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // Fold one byte into a reflected CRC-16 (poly 0xA001).
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/dsedf_front.sv
// Front side: accept input beats and classify them into tokens.
`timescale 1ns / 1ps
`default_nettype none
module dsedf_front (
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  input  wire logic [7:0]        in_rx_byte,
  input  wire dsedf_pkg::q_status_t q_stat,
  output logic                   in_stall,
  output logic                   push,
  output dsedf_pkg::token_t      push_tok
);
  import dsedf_pkg::*;

  token_kind_t kind;

  always_comb begin
    priority if (in_cmd) begin
      kind = TK_TIMEOUT;
    end else if (in_rx_byte == CH_STX) begin
      kind = TK_STX;
    end else if (in_rx_byte == CH_ETX) begin
      kind = TK_ETX;
    end else if (in_rx_byte == CH_DLE) begin
      kind = TK_DLE;
    end else begin
      kind = TK_BYTE;
    end
  end

  // Hold off the sender only when the queue has no room.
  assign in_stall         = q_stat.full;
  assign push             = in_valid && !q_stat.full;
  assign push_tok.kind    = kind;
  assign push_tok.rx_byte = in_rx_byte;

endmodule
`default_nettype wire

### rtl/dsedf_queue.sv
// Short token queue between the front and back sides.
`timescale 1ns / 1ps
`default_nettype none
module dsedf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire dsedf_pkg::token_t push_tok,
  input  wire logic              pop,
  output dsedf_pkg::q_status_t   q_stat,
  output dsedf_pkg::token_t      head_tok
);
  import dsedf_pkg::*;

  token_t            ent_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CW'(push) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_tok;
    end
  end

  assign q_stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign head_tok     = ent_r[rd_ptr_r];

endmodule
`default_nettype wire

### rtl/dsedf_back.sv
// Back side: framing state machine, CRC check and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "dle_stx_etx_deframer_crc16_top_macros.svh"
module dsedf_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [dsedf_pkg::LEN_W-1:0] cfg_data,
  input  wire dsedf_pkg::q_status_t q_stat,
  input  wire dsedf_pkg::token_t    head_tok,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_data_byte,
  output logic                      out_end_flag,
  output logic [1:0]                out_status,
  output logic [dsedf_pkg::LEN_W-1:0] out_body_length
);
  import dsedf_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [LEN_W-1:0]  max_len_r;
  logic [LEN_W-1:0]  limit;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        data_r;
  logic              end_r;
  status_t           status_r;
  logic [LEN_W-1:0]  blen_r;

  logic              emit, emit_end;
  status_t           emit_status;
  logic [7:0]        emit_data;
  logic              do_body, do_fin;
  logic [7:0]        body_val, fin_hi;

  assign limit = (max_len_r > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : max_len_r;

  // Take a token whenever the output register is free or draining.
  assign pop = q_stat.valid && (!out_valid_r || !out_stall);

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    len_nxt     = len_r;
    lo_nxt      = lo_r;
    emit        = 1'b0;
    emit_end    = 1'b0;
    emit_status = ST_OK;
    emit_data   = 8'h00;
    do_body     = 1'b0;
    do_fin      = 1'b0;
    body_val    = head_tok.rx_byte;
    fin_hi      = head_tok.rx_byte;
    if (pop) begin
      if (head_tok.kind == TK_TIMEOUT) begin
        emit        = 1'b1;
        emit_end    = 1'b1;
        emit_status = ST_TIMEOUT;
        phase_nxt   = PH_HUNT;
      end else begin
        unique case (phase_r)
          PH_BODY: begin
            if (head_tok.kind == TK_ETX) begin
              phase_nxt = PH_CRC0;
            end else if (head_tok.kind == TK_DLE) begin
              phase_nxt = PH_BODY_ESC;
            end else begin
              do_body = 1'b1;
            end
          end
          PH_BODY_ESC: begin
            do_body  = 1'b1;
            body_val = head_tok.rx_byte ^ ESC_FLIP;
          end
          PH_CRC0: begin
            if (head_tok.kind == TK_DLE) begin
              phase_nxt = PH_CRC0_ESC;
            end else begin
              lo_nxt    = head_tok.rx_byte;
              phase_nxt = PH_CRC1;
            end
          end
          PH_CRC0_ESC: begin
            lo_nxt    = head_tok.rx_byte ^ ESC_FLIP;
            phase_nxt = PH_CRC1;
          end
          PH_CRC1: begin
            if (head_tok.kind == TK_DLE) begin
              phase_nxt = PH_CRC1_ESC;
            end else begin
              do_fin = 1'b1;
            end
          end
          PH_CRC1_ESC: begin
            do_fin = 1'b1;
            fin_hi = head_tok.rx_byte ^ ESC_FLIP;
          end
          default: begin
            // Hunting, and any unused code: drop all but STX.
            phase_nxt = PH_HUNT;
            if (head_tok.kind == TK_STX) begin
              crc_nxt   = '0;
              len_nxt   = '0;
              lo_nxt    = '0;
              phase_nxt = PH_BODY;
            end
          end
        endcase
      end
    end

    if (do_body) begin
      emit = 1'b1;
      if (len_r >= limit) begin
        emit_end    = 1'b1;
        emit_status = ST_OVERRUN;
        phase_nxt   = PH_HUNT;
      end else begin
        crc_nxt   = crc16_byte(crc_r, body_val);
        len_nxt   = len_r + LEN_W'(1);
        phase_nxt = PH_BODY;
        emit_data = body_val;
      end
    end

    if (do_fin) begin
      emit        = 1'b1;
      emit_end    = 1'b1;
      emit_status = ({fin_hi, lo_r} == crc_r) ? ST_OK : ST_CRC_ERR;
      phase_nxt   = PH_HUNT;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      crc_r       <= '0;
      len_r       <= '0;
      lo_r        <= '0;
      max_len_r   <= LEN_W'(MAX_PACKET);
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
    end
  end

  // Load the output beat; hold it while stalled.
  always_ff @(posedge clk) begin
    if (emit) begin
      data_r   <= emit_data;
      end_r    <= emit_end;
      status_r <= emit_status;
      blen_r   <= emit_end ? len_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = data_r;
  assign out_end_flag    = end_r;
  assign out_status      = status_r;
  assign out_body_length = blen_r;

  `DSEDF_ASSERT(len_in_range, len_r <= LEN_W'(MAX_PACKET))
  `DSEDF_ASSERT(end_goes_hunt, (emit && emit_end) |=> (phase_r == PH_HUNT))
  `DSEDF_ASSERT(body_counts, (emit && !emit_end) |=> (len_r == $past(len_r) + LEN_W'(1)))
  `DSEDF_NEVER(pop_while_held, pop && out_valid_r && out_stall)

endmodule
`default_nettype wire

### rtl/dle_stx_etx_deframer_crc16_top.sv
// Top level of the DLE/STX/ETX deframer with CRC-16 check.
`timescale 1ns / 1ps
`default_nettype none
// DLE/STX/ETX deframer with CRC-16/ARC check. Each input beat is either a
// line byte (in_cmd = 0) or a receive timeout (in_cmd = 1). Bytes are dropped
// until STX opens a packet; in the body, ETX closes it and DLE makes the
// next byte a data byte XOR 0x40. Every decoded body byte leaves as an output
// beat with out_end_flag low. After ETX two check bytes, low byte first and
// each possibly escaped, are compared with the running CRC (poly 0xA001,
// init 0), and an end beat reports out_status (ok, crc error, timeout,
// overrun) and out_body_length. A timeout ends the packet at once, hunting
// included. Bodies longer than cfg max_len (capped at 1024) end with overrun.
// Rate: one beat per clock sustained, in and out, while out_stall is low; a
// beat's token is written into the four-entry token queue, and the back side,
// with its combinational CRC byte update, then loads its result into the
// output register.
// The token queue decouples the sides, so the input keeps flowing while
// a result waits until the queue fills. Write max_len only while idle;
// cfg_ready is always high.
module dle_stx_etx_deframer_crc16_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_cmd,
  input  wire logic [7:0]                  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_data_byte,
  output logic                             out_end_flag,
  output logic [1:0]                       out_status,
  output logic [dsedf_pkg::LEN_W-1:0]      out_body_length,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dsedf_pkg::LEN_W-1:0] cfg_data
);
  import dsedf_pkg::*;

  q_status_t q_stat;
  token_t    push_tok;
  token_t    head_tok;
  logic      push;
  logic      pop;

  // Configuration is always taken in the same cycle.
  assign cfg_ready = 1'b1;

  // Classify raw beats into tokens and push them when there is room.
  dsedf_front u_front (
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .in_stall   (in_stall),
    .push       (push),
    .push_tok   (push_tok)
  );

  // Buffer tokens so a stalled output does not stall the line at once.
  dsedf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .q_stat   (q_stat),
    .head_tok (head_tok)
  );

  // Run the framing FSM and CRC, one token per clock while not stalled.
  dsedf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .q_stat          (q_stat),
    .head_tok        (head_tok),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_end_flag    (out_end_flag),
    .out_status      (out_status),
    .out_body_length (out_body_length)
  );

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the DLE/STX/ETX deframer with CRC-16 check.
`timescale 1ns / 1ps
module tb;
  import dsedf_pkg::*;

  // Give up after this many clock cycles. A correct run is far shorter.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Let a beat that makes no result clear the token queue and the output register.
  localparam int DRAIN_CYCLES = 12;

  // Body bytes that exercise the framing: the framing codes themselves and
  // the bytes whose escaped form on the line is a framing code.
  localparam logic [7:0] TRICKY [6] = '{CH_STX, CH_ETX, CH_DLE,
                                        CH_STX ^ ESC_FLIP, CH_ETX ^ ESC_FLIP,
                                        CH_DLE ^ ESC_FLIP};

  typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_COMB} stall_mode_t;

  // One input beat: a line byte, or a receive timeout when cmd is high.
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } line_item_t;

  // One output beat, as predicted.
  typedef struct {
    logic [7:0]       data_byte;
    logic             end_flag;
    status_t          status;
    logic [LEN_W-1:0] body_length;
  } deframed_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_cmd = 1'b0;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_data_byte;
  logic             out_end_flag;
  logic [1:0]       out_status;
  logic [LEN_W-1:0] out_body_length;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  dle_stx_etx_deframer_crc16_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_end_flag    (out_end_flag),
    .out_status      (out_status),
    .out_body_length (out_body_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Line beats waiting to be offered, and output beats waiting to arrive.
  line_item_t     line_q[$];
  deframed_beat_t deframed_q[$];
  int unsigned    queued_items = 0;
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;

  // Shadow of the deframer state and of max_len, stepped on every accepted beat.
  phase_t           ph_model = PH_HUNT;
  logic [15:0]      crc_model = '0;
  logic [LEN_W-1:0] len_model = '0;
  logic [7:0]       crc_lo_model = '0;
  logic [LEN_W-1:0] max_len_model = LEN_W'(MAX_PACKET);

  // Reflected CRC-16, fed one bit at a time from the LSB of the byte.
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = {1'b0, r[15:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  // Queue the end beat of the packet and go back to hunting for STX.
  task automatic close_packet(input status_t st);
    deframed_beat_t e;
    e.data_byte   = '0;
    e.end_flag    = 1'b1;
    e.status      = st;
    e.body_length = len_model;
    deframed_q.push_back(e);
    ph_model = PH_HUNT;
  endtask

  // Take one decoded body byte, or end the packet on overrun.
  task automatic take_body_byte(input logic [7:0] b);
    deframed_beat_t e;
    logic [LEN_W-1:0] limit;
    limit = (max_len_model > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : max_len_model;
    if (len_model >= limit) begin
      close_packet(ST_OVERRUN);
    end else begin
      crc_model     = crc_fold(crc_model, b);
      len_model     = len_model + LEN_W'(1);
      ph_model      = PH_BODY;
      e.data_byte   = b;
      e.end_flag    = 1'b0;
      e.status      = ST_OK;
      e.body_length = '0;
      deframed_q.push_back(e);
    end
  endtask

  task automatic check_crc(input logic [7:0] hi);
    close_packet(({hi, crc_lo_model} == crc_model) ? ST_OK : ST_CRC_ERR);
  endtask

  // Advance the shadow deframer by one accepted line beat.
  task automatic deframe_step(input logic cmd, input logic [7:0] raw);
    if (cmd) begin
      close_packet(ST_TIMEOUT);
      return;
    end
    case (ph_model)
      PH_BODY: begin
        if (raw == CH_ETX) begin
          ph_model = PH_CRC0;
        end else if (raw == CH_DLE) begin
          ph_model = PH_BODY_ESC;
        end else begin
          take_body_byte(raw);
        end
      end
      PH_BODY_ESC: take_body_byte(raw ^ ESC_FLIP);
      PH_CRC0: begin
        if (raw == CH_DLE) begin
          ph_model = PH_CRC0_ESC;
        end else begin
          crc_lo_model = raw;
          ph_model     = PH_CRC1;
        end
      end
      PH_CRC0_ESC: begin
        crc_lo_model = raw ^ ESC_FLIP;
        ph_model     = PH_CRC1;
      end
      PH_CRC1: begin
        if (raw == CH_DLE) begin
          ph_model = PH_CRC1_ESC;
        end else begin
          check_crc(raw);
        end
      end
      PH_CRC1_ESC: check_crc(raw ^ ESC_FLIP);
      default: begin
        // Hunting, or a phase code with no meaning: only STX opens a packet.
        ph_model = PH_HUNT;
        if (raw == CH_STX) begin
          crc_model    = '0;
          len_model    = '0;
          crc_lo_model = '0;
          ph_model     = PH_BODY;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders: they only fill the line queue; the driver paces it.
  // ---------------------------------------------------------------------------
  task automatic push_raw(input logic cmd, input logic [7:0] b);
    line_item_t it;
    it.cmd     = cmd;
    it.rx_byte = b;
    line_q.push_back(it);
    queued_items++;
  endtask

  // Put one byte on the line, escaped with DLE where it must be, and also
  // at random with the given percentage. ETX only needs escaping in the body.
  task automatic push_coded(input logic [7:0] d, input int esc_pct, input bit in_body);
    if (d == CH_DLE || (in_body && d == CH_ETX) || $urandom_range(1, 100) <= esc_pct) begin
      push_raw(1'b0, CH_DLE);
      push_raw(1'b0, d ^ ESC_FLIP);
    end else begin
      push_raw(1'b0, d);
    end
  endtask

  // Frame a body with STX, ETX and its check bytes. Flip a check bit to
  // force a CRC error. A cut point aborts with a timeout: before body byte
  // cut, before ETX (cut = n), before the low check byte (n + 1), or before
  // the high check byte (n + 2). A negative cut runs the packet to its end.
  task automatic push_packet(input logic [7:0] body[$], input int esc_pct, input bit bad_crc,
                             input int cut);
    logic [15:0] chk;
    int n;
    n   = body.size();
    chk = '0;
    push_raw(1'b0, CH_STX);
    for (int i = 0; i < n; i++) begin
      if (i == cut) begin
        push_raw(1'b1, 8'($urandom));
        return;
      end
      push_coded(body[i], esc_pct, 1'b1);
      chk = crc_fold(chk, body[i]);
    end
    if (cut == n) begin
      push_raw(1'b1, 8'($urandom));
      return;
    end
    push_raw(1'b0, CH_ETX);
    if (bad_crc) chk = chk ^ (16'h0001 << $urandom_range(0, 15));
    if (cut == n + 1) begin
      push_raw(1'b1, 8'($urandom));
      return;
    end
    push_coded(chk[7:0], esc_pct, 1'b0);
    if (cut == n + 2) begin
      push_raw(1'b1, 8'($urandom));
      return;
    end
    push_coded(chk[15:8], esc_pct, 1'b0);
  endtask

  // Wait until every queued beat is in and every expected beat is out, then
  // let the pipeline settle so that beats without a result are done too.
  task automatic drain();
    while (line_q.size() != 0 || in_valid || deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  int unsigned hold_req = 0;

  // One setting of max_len and a stretch of mostly framed random traffic.
  // Lengths stay small, going just past a small limit so overrun shows up.
  task automatic run_phase(input logic [LEN_W-1:0] max_len, input int unsigned budget,
                           input bit hold_out, input int long_n);
    logic [7:0] body[$];
    int unsigned start;
    int n, pick, len_top;
    write_max_len(max_len);
    if (hold_out) hold_req++;
    if (long_n > 0) begin
      for (int i = 0; i < long_n; i++) body.push_back(8'($urandom));
      push_packet(body, 5, 1'b0, -1);
    end
    start   = queued_items;
    len_top = ((max_len < 10) ? int'(max_len) : 10) + 2;
    while (queued_items - start < budget) begin
      body.delete();
      n = $urandom_range(0, len_top);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          body.push_back(TRICKY[$urandom_range(0, 5)]);
        end else begin
          body.push_back(8'($urandom));
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_packet(body, $urandom_range(0, 30), 1'b0, -1);
      end else if (pick < 72) begin
        push_packet(body, $urandom_range(0, 30), 1'b1, -1);
      end else if (pick < 82) begin
        push_packet(body, $urandom_range(0, 30), 1'b0, $urandom_range(0, n + 2));
      end else if (pick < 90) begin
        // Line noise between packets, now and then a stray timeout.
        repeat ($urandom_range(1, 4)) push_raw($urandom_range(0, 7) == 0, 8'($urandom));
      end else begin
        // Broken packet: STX and a few bytes, then the next packet starts.
        push_raw(1'b0, CH_STX);
        foreach (body[i]) push_raw(1'b0, body[i]);
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: change at the falling edge, hold a stalled beat, and
  // offer beats in bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------------
  logic beat_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      ph_model      = PH_HUNT;
      crc_model     = '0;
      len_model     = '0;
      crc_lo_model  = '0;
      max_len_model = LEN_W'(MAX_PACKET);
      beat_taken   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_len_model = cfg_data;
      if (in_valid && !in_stall) begin
        deframe_step(in_cmd, in_rx_byte);
        line_q.delete(0);
        beat_taken <= 1'b1;
      end else begin
        beat_taken <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !beat_taken)) begin
      // The last beat went in, or nothing was offered: pick the next move.
      if (gap_left > 0) begin
        gap_left--;
      end else if (line_q.size() > 0) begin
        go = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= go;
      if (go) begin
        in_cmd     <= line_q[0].cmd;
        in_rx_byte <= line_q[0].rx_byte;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: switch between stall patterns, and on request hold off
  // for a long stretch so the token queue fills and the input stalls.
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  int unsigned hold_served = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && hold_served != hold_req) begin
        hold_left = $urandom_range(200, 320);
        hold_served++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) == 0);
          STALL_COMB:  out_stall <= ((stall_tick % 5) < 2);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge and match each output beat against
  // the oldest expected beat, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [LEN_W-1:0] want_v,
                             input logic [LEN_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deframed_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got data=%0d end=%0d status=%0d len=%0d",
                 $time, out_data_byte, out_end_flag, out_status, out_body_length);
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        check_field("data_byte", LEN_W'(want.data_byte), LEN_W'(out_data_byte));
        check_field("end_flag", LEN_W'(want.end_flag), LEN_W'(out_end_flag));
        check_field("status", LEN_W'(want.status), LEN_W'(out_status));
        check_field("body_length", want.body_length, out_body_length);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[dle_stx_etx_deframer_crc16_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] body[$];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset max_len of 1024.
    // Timeout while hunting: end beat with zero length.
    push_raw(1'b1, 8'hA5);
    // DLE while hunting is just dropped.
    push_raw(1'b0, CH_DLE);
    // STX in the body is data; ETX and DLE in the body must go escaped.
    body = '{CH_STX, CH_ETX, CH_DLE, 8'hFF};
    push_packet(body, 0, 1'b0, -1);
    // Escaped STX and ETX on the line, escaped check bytes.
    body = '{CH_STX ^ ESC_FLIP, CH_ETX ^ ESC_FLIP};
    push_packet(body, 100, 1'b0, -1);
    // Empty body with a wrong check word.
    body.delete();
    push_packet(body, 0, 1'b1, -1);
    drain();

    // Sweep max_len: zero turns any body byte into overrun, 2047 and 1024
    // both cap at the packet limit, which one long packet reaches.
    run_phase(LEN_W'(0), 65, 1'b0, 0);
    run_phase(LEN_W'(1), 65, 1'b1, 0);
    run_phase(LEN_W'(2047), 40, 1'b0, 1030);
    run_phase(LEN_W'(3), 65, 1'b0, 0);
    run_phase(LEN_W'(1024), 40, 1'b1, 0);
    run_phase(LEN_W'($urandom_range(4, 16)), 65, 1'b0, 0);
    run_phase(LEN_W'($urandom_range(0, 2047)), 65, 1'b0, 0);
    run_phase(LEN_W'(1023), 65, 1'b1, 0);

    if (fail_count == 0) begin
      $display("[dle_stx_etx_deframer_crc16_top] OK");
    end else begin
      $display("[dle_stx_etx_deframer_crc16_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dsedf_pkg.sv
rtl/dsedf_front.sv
rtl/dsedf_queue.sv
rtl/dsedf_back.sv
rtl/dle_stx_etx_deframer_crc16_top.sv
tb/tb.sv
